FILE: rtl/json_string_unescape_utf8_macros.svh
// assertion macros shared by the json string unescaper rtl
// expects clk and rst in the scope of the module that uses them
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication, checked out of reset
`define JSU_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu check failed");

// next-cycle implication, checked out of reset
`define JSU_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu next-cycle check failed");

`endif

FILE: rtl/jsu_pkg.sv
// package for the json string unescaper: command type, queue sizing, byte codes
// no dependencies
`default_nettype none

package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef enum logic {
    KIND_BYTE,
    KIND_CODE
  } kind_t;

  // one command per item that yields output; code kind expands to 1..3 bytes
  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic        has_byte;
    logic        last;
    logic        trunc;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/jsu_front.sv
// front end: accepts content bytes, tracks escape state, issues commands
// depends on jsu_pkg
`default_nettype none

module jsu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  output jsu_pkg::cmd_t      cmd,
  output logic               cmd_valid
);

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_ESC   = 3'b010,
    MODE_HEX   = 3'b100
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_accum, code_accum_next;
  logic        stopped, stopped_next;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [7:0]  esc_byte;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    case (in_byte)
      jsu_pkg::CH_N: esc_byte = 8'h0A;
      jsu_pkg::CH_T: esc_byte = 8'h09;
      jsu_pkg::CH_R: esc_byte = 8'h0D;
      jsu_pkg::CH_B: esc_byte = 8'h08;
      jsu_pkg::CH_F: esc_byte = 8'h0C;
      default:       esc_byte = in_byte;
    endcase
  end

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    stopped_next    = stopped;
    cmd_valid       = 1'b0;
    cmd             = '0;
    cmd.kind        = jsu_pkg::KIND_BYTE;
    if (stopped) begin
      if (in_last) begin
        cmd_valid = 1'b1;
        cmd.last  = 1'b1;
        cmd.trunc = 1'b1;
      end
    end else begin
      case (mode)
        MODE_ESC: begin
          if (in_byte == jsu_pkg::CH_U) begin
            if (in_last) begin
              cmd_valid = 1'b1;
              cmd.last  = 1'b1;
              cmd.trunc = 1'b1;
            end else begin
              mode_next       = MODE_HEX;
              hex_count_next  = 2'd0;
              code_accum_next = 16'd0;
            end
          end else begin
            cmd_valid    = 1'b1;
            cmd.value    = {8'd0, esc_byte};
            cmd.has_byte = 1'b1;
            cmd.last     = in_last;
            mode_next    = MODE_PLAIN;
          end
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            stopped_next = 1'b1;
            if (in_last) begin
              cmd_valid = 1'b1;
              cmd.last  = 1'b1;
              cmd.trunc = 1'b1;
            end
          end else if (hex_count == 2'd3) begin
            cmd_valid       = 1'b1;
            cmd.kind        = jsu_pkg::KIND_CODE;
            cmd.value       = {code_accum[11:0], hex_val};
            cmd.has_byte    = 1'b1;
            cmd.last        = in_last;
            mode_next       = MODE_PLAIN;
            hex_count_next  = 2'd0;
            code_accum_next = 16'd0;
          end else begin
            code_accum_next = {code_accum[11:0], hex_val};
            hex_count_next  = hex_count + 2'd1;
            if (in_last) begin
              cmd_valid = 1'b1;
              cmd.last  = 1'b1;
              cmd.trunc = 1'b1;
            end
          end
        end
        default: begin
          mode_next = MODE_PLAIN;
          if (in_byte == jsu_pkg::CH_BACKSLASH && !in_last) begin
            mode_next = MODE_ESC;
          end else begin
            cmd_valid    = 1'b1;
            cmd.value    = {8'd0, in_byte};
            cmd.has_byte = 1'b1;
            cmd.last     = in_last;
          end
        end
      endcase
    end
    // end of string returns everything to reset values
    if (in_last) begin
      mode_next       = MODE_PLAIN;
      hex_count_next  = 2'd0;
      code_accum_next = 16'd0;
      stopped_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PLAIN;
      hex_count  <= 2'd0;
      code_accum <= 16'd0;
      stopped    <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
      stopped    <= stopped_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/jsu_cmdq.sv
// command queue between front and back ends
// depends on jsu_pkg and the assertion macro header
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"

module jsu_cmdq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  jsu_pkg::cmd_t      wr_data,
  input  wire logic          rd_en,
  output jsu_pkg::cmd_t      rd_data,
  output logic               full,
  output logic               empty
);

  jsu_pkg::cmd_t          entries [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0] wr_ptr;
  logic [jsu_pkg::QAW-1:0] rd_ptr;
  logic [jsu_pkg::QAW:0]   count;

  assign full    = (count == (jsu_pkg::QAW+1)'(jsu_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + (jsu_pkg::QAW)'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + (jsu_pkg::QAW)'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + (jsu_pkg::QAW+1)'(1);
        2'b01:   count <= count - (jsu_pkg::QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  `JSU_CHECK(a_no_overflow, full, !wr_en)
  `JSU_CHECK(a_no_underflow, empty, !rd_en)
  `JSU_CHECK(a_count_bound, 1'b1, count <= (jsu_pkg::QAW+1)'(jsu_pkg::QDEPTH))

endmodule

`default_nettype wire

FILE: rtl/jsu_back.sv
// back end: takes commands and expands them into result items (utf-8 encoder)
// depends on jsu_pkg and the assertion macro header
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"

module jsu_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  jsu_pkg::cmd_t      q_data,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         out_byte,
  output logic               has_byte,
  output logic               out_last,
  output logic               truncated
);

  jsu_pkg::cmd_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic [1:0]    nbytes;
  logic          final_piece;
  logic          take;

  always_comb begin
    if (cur.kind == jsu_pkg::KIND_BYTE) begin
      nbytes = 2'd1;
    end else if (cur.value[15:11] != 5'd0) begin
      nbytes = 2'd3;
    end else if (cur.value[10:7] != 4'd0) begin
      nbytes = 2'd2;
    end else begin
      nbytes = 2'd1;
    end
  end

  assign final_piece = (idx == nbytes - 2'd1);

  always_comb begin
    out_byte = cur.value[7:0];
    case (nbytes)
      2'd2: begin
        case (idx)
          2'd0:    out_byte = jsu_pkg::UTF8_LEAD2 | {3'd0, cur.value[10:6]};
          default: out_byte = jsu_pkg::UTF8_CONT | {2'd0, cur.value[5:0]};
        endcase
      end
      2'd3: begin
        case (idx)
          2'd0:    out_byte = jsu_pkg::UTF8_LEAD3 | {4'd0, cur.value[15:12]};
          2'd1:    out_byte = jsu_pkg::UTF8_CONT | {2'd0, cur.value[11:6]};
          default: out_byte = jsu_pkg::UTF8_CONT | {2'd0, cur.value[5:0]};
        endcase
      end
      default: out_byte = cur.value[7:0];
    endcase
  end

  assign has_byte  = cur.has_byte;
  assign out_last  = cur.last && final_piece;
  assign truncated = cur.trunc;
  assign empty     = !cur_valid;

  assign take  = !cur_valid || (pop && final_piece);
  assign q_pop = take && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (take) begin
      cur_valid <= !q_empty;
      idx       <= 2'd0;
    end else if (pop) begin
      idx <= idx + 2'd1;
    end
  end

  `JSU_CHECK_NEXT(a_mid_piece_stays, cur_valid && pop && !final_piece, cur_valid)
  `JSU_CHECK(a_trunc_is_marker, cur_valid && truncated, !has_byte && out_last)
  `JSU_CHECK(a_idx_in_range, cur_valid, idx < nbytes)

endmodule

`default_nettype wire

FILE: rtl/json_string_unescape_utf8.sv
// path: an item's command goes into the command queue, then into the output register
// throughput: one input item per cycle unless full, one result per cycle while pop is high;
// a \u escape expands to up to three results; the four-entry command queue absorbs bursts
// full rises only when the command queue is full; empty follows the back end's register
// reset (rst, synchronous): escape state clears, queue and output register empty
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            has_byte,
  output logic            out_last,
  output logic            truncated
);

  jsu_pkg::cmd_t front_cmd;
  logic          front_cmd_valid;
  logic          accept;
  jsu_pkg::cmd_t q_data;
  logic          q_empty;
  logic          q_pop;

  assign accept = push && !full;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd       (front_cmd),
    .cmd_valid (front_cmd_valid)
  );

  jsu_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && front_cmd_valid),
    .wr_data (front_cmd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (full),
    .empty   (q_empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last),
    .truncated (truncated)
  );

endmodule

`default_nettype wire
